/* hdl/distinct_window_marker_detect_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the distinct window marker detector
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DISTINCT_WINDOW_MARKER_DETECT_DEFINES_SVH
`define DISTINCT_WINDOW_MARKER_DETECT_DEFINES_SVH

// Same-cycle implication checked at every rising edge out of reset.
`define DWMD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked at every rising edge out of reset.
`define DWMD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/dwmd_pkg.sv */
// ----------------------------------------------------------------------------
// dwmd_pkg
// Shared constants and types of the distinct window marker detector.
// ----------------------------------------------------------------------------
package dwmd_pkg;

    localparam int MAX_WINDOW_DEF = 32;
    localparam int POS_BITS_DEF   = 16;

    localparam int SYM_W       = 8;
    localparam int NUM_SYMBOLS = 256;
    localparam int MARKER_W    = 16;
    localparam int WL_W        = 6;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [WL_W-1:0] WL_RESET = 6'd4;

    // Register index, taken from paddr[2].
    localparam logic REG_WINDOW_LENGTH = 1'b0;

    // Result handed from the scan stage to the output register.
    typedef struct packed {
        logic                valid;
        logic                found;
        logic [MARKER_W-1:0] marker_end;
    } scan_result_t;

    // Handshake status of the scan stage.
    typedef struct packed {
        logic busy;
        logic fire;
        logic ready;
    } scan_status_t;

endpackage

/* hdl/distinct_window_marker_detect.sv */
// Bytes are held in the scan stage and results in the output register. Throughput:
// one byte per cycle unless a result waits, set by one read and one write of the
// position RAM per byte; a write forwarded to the next read keeps repeats fast.
// Reset: rst_n clears valid bits, search state and window_length (to 4) at once;
// no clearing pass, the byte after reset may follow immediately.
// ----------------------------------------------------------------------------
// distinct_window_marker_detect
// Finds, per line, the first byte that ends a run of window_length distinct bytes.
// ----------------------------------------------------------------------------
module distinct_window_marker_detect
    import dwmd_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF,
    parameter int POS_BITS   = POS_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Byte stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] symbol
    input  logic                  s_tlast,   // line_last
    input  logic                  s_tuser,   // line_first
    // Result stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,   // [15:0] marker_end
    output logic                  m_tuser,   // found
    // Configuration.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    `include "distinct_window_marker_detect_defines.svh"

    logic [WL_W-1:0]     window_length;
    logic                in_fire;
    logic                room;
    logic [POS_BITS-1:0] rd_data;
    logic                wr_en;
    logic [SYM_W-1:0]    wr_addr;
    logic [POS_BITS-1:0] wr_data;
    scan_result_t        result;
    scan_status_t        status;

    logic                out_valid_reg;
    logic                out_found_reg;
    logic [MARKER_W-1:0] out_marker_reg;

    dwmd_cfg u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .window_length (window_length)
    );

    // The table read is launched at the accept edge, so the data is there
    // while the byte sits in the scan stage.
    dwmd_pos_ram #(
        .POS_BITS (POS_BITS)
    ) u_ram (
        .clk     (clk),
        .rd_en   (in_fire),
        .rd_addr (s_tdata[SYM_W-1:0]),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    dwmd_scan #(
        .MAX_WINDOW (MAX_WINDOW),
        .POS_BITS   (POS_BITS)
    ) u_scan (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_fire       (in_fire),
        .in_symbol     (s_tdata[SYM_W-1:0]),
        .in_first      (s_tuser),
        .in_last       (s_tlast),
        .room          (room),
        .window_length (window_length),
        .rd_data       (rd_data),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .result        (result),
        .status        (status)
    );

    // The scan stage moves on whenever its byte yields no result, so bytes
    // keep flowing while a finished result waits in the output register.
    assign s_tready = status.ready;
    assign in_fire  = s_tvalid && s_tready;
    assign room     = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (result.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result.valid)
        begin
            out_found_reg  <= result.found;
            out_marker_reg <= result.marker_end;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_found_reg;
    assign m_tdata  = out_marker_reg;

    // A not-found result always carries a zero count.
    `DWMD_ASSERT_NOW(a_notfound_zero, m_tvalid && !m_tuser, m_tdata == '0, "not-found result with nonzero marker_end")

    // A pending result that cannot be stored must hold the input side.
    `DWMD_ASSERT_NOW(a_stall_blocks_input, status.busy && !status.fire, !s_tready, "input accepted while scan stage is stalled")

    // A taken result with nothing new behind it leaves the output empty.
    `DWMD_ASSERT_NEXT(a_out_drains, m_tvalid && m_tready && !result.valid, !m_tvalid, "result repeated after being taken")

endmodule

/* hdl/dwmd_cfg.sv */
// ----------------------------------------------------------------------------
// dwmd_cfg
// APB register file holding the window length.
// ----------------------------------------------------------------------------
module dwmd_cfg
    import dwmd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [WL_W-1:0]       window_length
);

    logic [WL_W-1:0] wl_reg;
    logic            wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_WINDOW_LENGTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wl_reg <= WL_RESET;
        end
        else if (wr_en)
        begin
            wl_reg <= pwdata[WL_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_WINDOW_LENGTH)
        begin
            prdata = CFG_DATA_W'(wl_reg);
        end
    end

    assign window_length = wl_reg;

endmodule

/* hdl/dwmd_pos_ram.sv */
// ----------------------------------------------------------------------------
// dwmd_pos_ram
// Last-seen position table, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module dwmd_pos_ram
    import dwmd_pkg::*;
#(
    parameter int POS_BITS = POS_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rd_en,
    input  logic [SYM_W-1:0]    rd_addr,
    output logic [POS_BITS-1:0] rd_data,
    input  logic                wr_en,
    input  logic [SYM_W-1:0]    wr_addr,
    input  logic [POS_BITS-1:0] wr_data
);

    logic [POS_BITS-1:0] mem [NUM_SYMBOLS];
    logic [POS_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read-before-write; the scan stage forwards a colliding write.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/dwmd_scan.sv */
// ----------------------------------------------------------------------------
// dwmd_scan
// Window update stage: valid bits, forwarding and per-line search state.
// ----------------------------------------------------------------------------
module dwmd_scan
    import dwmd_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF,
    parameter int POS_BITS   = POS_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_fire,
    input  logic [SYM_W-1:0]    in_symbol,
    input  logic                in_first,
    input  logic                in_last,
    input  logic                room,
    input  logic [WL_W-1:0]     window_length,
    input  logic [POS_BITS-1:0] rd_data,
    output logic                wr_en,
    output logic [SYM_W-1:0]    wr_addr,
    output logic [POS_BITS-1:0] wr_data,
    output scan_result_t        result,
    output scan_status_t        status
);

    localparam int NEED_W = $clog2(MAX_WINDOW + 1);
    localparam int CMP_W  = (POS_BITS > NEED_W) ? POS_BITS : NEED_W;
    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

    // Item held in the stage, its read data arriving from the table.
    logic                   b_valid_reg;
    logic [SYM_W-1:0]       b_sym_reg;
    logic                   b_first_reg;
    logic                   b_last_reg;

    // Last table write when it coincided with this item's read.
    logic                   fwd_valid_reg;
    logic [SYM_W-1:0]       fwd_sym_reg;
    logic [POS_BITS-1:0]    fwd_pos_reg;

    logic [POS_BITS-1:0]    wb_reg;
    logic [POS_BITS-1:0]    pos_reg;
    logic                   done_reg;
    logic [NUM_SYMBOLS-1:0] sv_reg;

    logic [NEED_W-1:0]      need;
    logic                   done0;
    logic [POS_BITS-1:0]    wb0;
    logic [POS_BITS-1:0]    pos0;
    logic [NUM_SYMBOLS-1:0] sv0;
    logic                   hit;
    logic [POS_BITS-1:0]    last_pos;
    logic                   rec;
    logic [POS_BITS-1:0]    wb_new;
    logic [POS_BITS-1:0]    pos_inc;
    logic [POS_BITS-1:0]    run_len;
    logic                   hit_found;
    logic                   has_result;
    logic                   fire;
    logic [31:0]            pos_inc_w;

    always_comb
    begin
        if (window_length == '0)
        begin
            need = NEED_W'(1);
        end
        else if (32'(window_length) > MAX_WINDOW)
        begin
            need = NEED_W'(MAX_WINDOW);
        end
        else
        begin
            need = NEED_W'(window_length);
        end
    end

    always_comb
    begin
        // A line start clears the search state before the byte is handled.
        done0 = b_first_reg ? 1'b0 : done_reg;
        wb0   = b_first_reg ? '0 : wb_reg;
        pos0  = b_first_reg ? '0 : pos_reg;
        sv0   = b_first_reg ? '0 : sv_reg;

        hit      = sv0[b_sym_reg];
        last_pos = (fwd_valid_reg && (fwd_sym_reg == b_sym_reg)) ? fwd_pos_reg : rd_data;
        rec      = !done0 && (pos0 != POS_MAX);

        wb_new = wb0;
        if (hit && (last_pos >= wb0))
        begin
            wb_new = last_pos + POS_BITS'(1);
        end

        pos_inc    = pos0 + POS_BITS'(1);
        run_len    = pos_inc - wb_new;
        hit_found  = rec && (CMP_W'(run_len) >= CMP_W'(need));
        has_result = !done0 && (hit_found || b_last_reg);
        fire       = b_valid_reg && (!has_result || room);
        pos_inc_w  = 32'(pos_inc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
            wb_reg        <= '0;
            pos_reg       <= '0;
            done_reg      <= 1'b0;
            sv_reg        <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                b_valid_reg   <= 1'b1;
                fwd_valid_reg <= fire && rec;
            end
            else if (fire)
            begin
                b_valid_reg <= 1'b0;
            end

            if (fire)
            begin
                wb_reg   <= rec ? wb_new : wb0;
                pos_reg  <= rec ? pos_inc : pos0;
                done_reg <= done0 || has_result;
                sv_reg   <= sv0 | (rec ? (NUM_SYMBOLS'(1) << b_sym_reg) : '0);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            b_sym_reg   <= in_symbol;
            b_first_reg <= in_first;
            b_last_reg  <= in_last;
            fwd_sym_reg <= b_sym_reg;
            fwd_pos_reg <= pos0;
        end
    end

    assign wr_en   = fire && rec;
    assign wr_addr = b_sym_reg;
    assign wr_data = pos0;

    assign result.valid      = fire && has_result;
    assign result.found      = hit_found;
    assign result.marker_end = hit_found ? pos_inc_w[MARKER_W-1:0] : '0;

    assign status.busy  = b_valid_reg;
    assign status.fire  = fire;
    assign status.ready = !b_valid_reg || fire;

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the distinct window marker detector. Lines of bytes
// are streamed in and a predictor tracks the per-line search. Each result
// transaction is checked against the oldest predicted marker. The window
// length register is set to its extremes and to random values between segments.
// ----------------------------------------------------------------------------
module tb;
    import dwmd_pkg::*;

    // Longest stretch of cycles without any accepted transaction.
    localparam int WATCHDOG_LIMIT = 4000;
    // Length of the deliberate output stall that backs up the block.
    localparam int HOLDOFF_CYCLES = 300;
    // Position at which the block stops counting bytes in a line.
    localparam int POS_LIMIT      = (1 << POS_BITS_DEF) - 1;
    // Random bytes per window setting; some fall after a find and are ignored.
    localparam int SEG_BYTES      = 150;

    typedef struct {
        logic [SYM_W-1:0] symbol;
        logic             line_first;
        logic             line_last;
    } line_byte_t;

    typedef struct {
        logic [MARKER_W-1:0] marker_end;
        logic                found;
    } marker_result_t;

    // Every input of the block starts at a known value.
    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata  = '0;   // [7:0] symbol
    logic                  s_tlast  = 1'b0; // line_last
    logic                  s_tuser  = 1'b0; // line_first
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [15:0]           m_tdata;         // [15:0] marker_end
    logic                  m_tuser;         // found
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr    = '0;
    logic [CFG_DATA_W-1:0] pwdata   = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // Bytes waiting to be driven, and markers waiting to come out.
    line_byte_t     byte_queue[$];
    marker_result_t marker_queue[$];
    line_byte_t     cur_byte;

    // Predictor state: one copy of the search state of the block.
    int                     pos_table [NUM_SYMBOLS];
    bit [NUM_SYMBOLS-1:0]   pos_seen    = '0;
    int                     run_start   = 0;
    int                     next_pos    = 0;
    bit                     line_closed = 1'b0;
    logic [WL_W-1:0]        wl_shadow   = WL_RESET;

    // Idle percentages of both sides and the pending output stall.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles   = 0;

    int error_count     = 0;
    int bytes_sent      = 0;
    int lines_sent      = 0;
    int found_count     = 0;
    int miss_count      = 0;
    int window_settings = 0;
    int quiet_cycles    = 0;

    distinct_window_marker_detect uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 8 ns clock.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Only the first ten mismatches are printed; the rest are just counted.
    function automatic void log_error(input string msg);
        error_count++;
        if (error_count <= 10)
        begin
            $display("tb: mismatch at %0t: %s", $realtime, msg);
        end
    endfunction

    // Advances the line search by one accepted byte and queues the marker
    // result, if that byte produces one.
    function automatic void track_marker_search(input line_byte_t b);
        int need;
        int last_at;
        marker_result_t res;
        need = int'(wl_shadow);
        if (need < 1)
        begin
            need = 1;
        end
        if (need > MAX_WINDOW_DEF)
        begin
            need = MAX_WINDOW_DEF;
        end
        // A line start wipes the seen bits and the run start.
        if (b.line_first)
        begin
            pos_seen    = '0;
            run_start   = 0;
            next_pos    = 0;
            line_closed = 1'b0;
        end
        if (line_closed)
        begin
            return;
        end
        // A byte at the saturated position is neither recorded nor counted.
        if (next_pos < POS_LIMIT)
        begin
            last_at = pos_table[b.symbol];
            // A repeat inside the run moves the run start past the old copy.
            if (pos_seen[b.symbol] && last_at >= run_start)
            begin
                run_start = last_at + 1;
            end
            pos_table[b.symbol] = next_pos;
            pos_seen[b.symbol]  = 1'b1;
            next_pos            = next_pos + 1;
            if (next_pos - run_start >= need)
            begin
                line_closed    = 1'b1;
                res.marker_end = MARKER_W'(next_pos);
                res.found      = 1'b1;
                marker_queue.insert(marker_queue.size(), res);
                return;
            end
        end
        // End of line without a find gives a not-found result.
        if (b.line_last)
        begin
            line_closed    = 1'b1;
            res.marker_end = '0;
            res.found      = 1'b0;
            marker_queue.insert(marker_queue.size(), res);
        end
    endfunction

    // Driver: holds a byte until its transaction completes, then either
    // presents the next pending byte or idles, at random or when none is pending.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                track_marker_search(cur_byte);
                bytes_sent++;
                if (cur_byte.line_first)
                begin
                    lines_sent++;
                end
            end
            if (!s_tvalid || s_tready)
            begin
                if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cur_byte = byte_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= cur_byte.symbol;
                    s_tuser  <= cur_byte.line_first;
                    s_tlast  <= cur_byte.line_last;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random back-pressure, or a long stall when one is requested.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_cycles > 0)
            begin
                hold_cycles <= hold_cycles - 1;
                m_tready    <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Monitor: every result transaction is matched against the oldest
    // predicted marker.
    always @(posedge clk)
    begin
        marker_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (marker_queue.size() == 0)
            begin
                log_error($sformatf("unexpected result marker_end %0d found %0b",
                                    m_tdata, m_tuser));
            end
            else
            begin
                want = marker_queue.pop_front();
                if (m_tuser !== want.found)
                begin
                    log_error($sformatf("found expected %0b got %0b",
                                        want.found, m_tuser));
                end
                if (m_tdata !== want.marker_end)
                begin
                    log_error($sformatf("marker_end expected %0d got %0d",
                                        want.marker_end, m_tdata));
                end
                if (want.found)
                begin
                    found_count++;
                end
                else
                begin
                    miss_count++;
                end
            end
        end
    end

    // Watchdog: ends the run when no transaction of any kind completes for
    // too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb: watchdog expired after %0d quiet cycles", quiet_cycles);
                $display("tb: done, errors");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    function automatic void push_byte(input logic [SYM_W-1:0] sym, input logic first,
                                      input logic last);
        line_byte_t b;
        b.symbol     = sym;
        b.line_first = first;
        b.line_last  = last;
        byte_queue.insert(byte_queue.size(), b);
    endfunction

    // One register transaction: setup cycle, then access cycle until pready.
    task automatic apb_transfer(input logic wr, input logic [CFG_DATA_W-1:0] wdata,
                                output logic [CFG_DATA_W-1:0] rdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {REG_WINDOW_LENGTH, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Writes window_length with junk in the unused upper bits, then reads it
    // back; only the low six bits are expected to stick.
    task automatic set_window(input logic [WL_W-1:0] wl);
        logic [CFG_DATA_W-1:0] wdata;
        logic [CFG_DATA_W-1:0] rdata;
        wdata = $urandom;
        wdata[WL_W-1:0] = wl;
        apb_transfer(1'b1, wdata, rdata);
        wl_shadow = wl;
        apb_transfer(1'b0, '0, rdata);
        if (rdata !== CFG_DATA_W'(wl))
        begin
            log_error($sformatf("window_length readback expected %0d got %0d", wl, rdata));
        end
        window_settings++;
    endtask

    // Waits until every byte has been taken and every marker has come out,
    // then gives the block time to finish a byte with no result.
    task automatic wait_drained();
        while (byte_queue.size() != 0 || s_tvalid || marker_queue.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    // Mostly well-formed lines drawn from a small alphabet, so that repeats
    // are common and markers sometimes complete. About one in ten items is a
    // stray byte with random flags, and some lines never get their end flag.
    task automatic queue_random_lines(input int budget);
        int need;
        int made;
        int len;
        int alpha;
        int base;
        bit broken;
        need = (wl_shadow == 0) ? 1 : int'(wl_shadow);
        if (need > MAX_WINDOW_DEF)
        begin
            need = MAX_WINDOW_DEF;
        end
        made = 0;
        while (made < budget)
        begin
            if ($urandom_range(9) == 0)
            begin
                push_byte(SYM_W'($urandom_range(255)), 1'($urandom_range(1)),
                          1'($urandom_range(1)));
                made++;
            end
            else
            begin
                len    = $urandom_range(1, 3 * need + 4);
                alpha  = ($urandom_range(7) == 0) ? NUM_SYMBOLS
                                                  : $urandom_range(need, need + need / 2 + 2);
                base   = $urandom_range(255);
                broken = ($urandom_range(11) == 0);
                for (int i = 0; i < len; i++)
                begin
                    push_byte(SYM_W'(base + $urandom_range(alpha - 1)), i == 0,
                              (i == len - 1) && !broken);
                end
                made += len;
            end
        end
    endtask

    initial
    begin
        logic [WL_W-1:0] seg_windows [9];

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, at the reset window length of four.
        send_idle_pct = 13;
        recv_idle_pct = 52;
        // Bytes before any line start count as the first line; the bytes
        // after the find, end flag included, are ignored.
        push_byte(8'h61, 1'b0, 1'b0);
        push_byte(8'h62, 1'b0, 1'b0);
        push_byte(8'h63, 1'b0, 1'b0);
        push_byte(8'h64, 1'b0, 1'b0);
        push_byte(8'h65, 1'b0, 1'b1);
        // One-byte line: start and end on the same byte.
        push_byte(8'h00, 1'b1, 1'b1);
        // The window that closes on the last byte of the line still counts.
        push_byte(8'hFF, 1'b1, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'h01, 1'b0, 1'b0);
        push_byte(8'h02, 1'b0, 1'b1);
        // Alternating pair never forms a marker: not-found result.
        push_byte(8'h55, 1'b1, 1'b0);
        push_byte(8'hAA, 1'b0, 1'b0);
        push_byte(8'h55, 1'b0, 1'b0);
        push_byte(8'hAA, 1'b0, 1'b1);
        // A byte last seen before the current run start must not move it.
        push_byte(8'h10, 1'b1, 1'b0);
        push_byte(8'h20, 1'b0, 1'b0);
        push_byte(8'h20, 1'b0, 1'b0);
        push_byte(8'h10, 1'b0, 1'b0);
        push_byte(8'h30, 1'b0, 1'b0);
        push_byte(8'h40, 1'b0, 1'b1);
        wait_drained();

        // Stall the result side for a long stretch while short lines keep
        // coming, so that the block backs up and drops s_tready. The drain
        // afterwards doubles as a pause of the sender.
        hold_cycles = HOLDOFF_CYCLES;
        repeat (48) push_byte(SYM_W'($urandom_range(255)), 1'b1, 1'b1);
        wait_drained();

        // Window settings, three per phase: extremes first, random picks mixed in later.
        seg_windows[0] = 6'd2;
        seg_windows[1] = 6'd0;
        seg_windows[2] = 6'd32;
        seg_windows[3] = 6'd1;
        seg_windows[4] = 6'd63;
        seg_windows[5] = WL_W'($urandom_range(1, 40));
        seg_windows[6] = 6'd33;
        seg_windows[7] = WL_W'($urandom_range(0, 63));
        seg_windows[8] = WL_W'($urandom_range(1, 12));

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 13;
                    recv_idle_pct = 52;
                end
                1:
                begin
                    send_idle_pct = 52;
                    recv_idle_pct = 13;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int seg = 0; seg < 3; seg++)
            begin
                set_window(seg_windows[3 * phase + seg]);
                queue_random_lines(SEG_BYTES);
                wait_drained();
            end
        end

        repeat (8) @(posedge clk);
        $display("tb: %0d bytes in %0d lines, %0d markers found, %0d lines ended without",
                 bytes_sent, lines_sent, found_count, miss_count);
        $display("tb: %0d window settings and a %0d-cycle output stall",
                 window_settings, HOLDOFF_CYCLES);
        if (error_count == 0)
        begin
            $display("tb: done, clean");
        end
        else
        begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hdl
hdl/dwmd_pkg.sv
hdl/dwmd_cfg.sv
hdl/dwmd_pos_ram.sv
hdl/dwmd_scan.sv
hdl/distinct_window_marker_detect.sv
dv/tb.sv
